>>> src/arsg_pkg.sv
package arsg_pkg;

   // Field widths.
   localparam int COORD_W = 12;
   localparam int RAD_W   = 10;
   localparam int ANG_W   = 9;
   localparam int ROW_W   = 11;
   localparam int OUT_W   = 13;
   localparam int LEN_W   = 10;
   localparam int NUM_W   = 16;
   localparam int DEN_W   = 11;
   localparam int QUO_W   = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 12;
   localparam int NUM_TESTS = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THICKNESS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END       = 3'd5;

   // Angle constants in degrees.
   localparam logic [15:0] DEG_540 = 16'd540;
   localparam logic [15:0] DEG_360 = 16'd360;
   localparam logic [15:0] DEG_180 = 16'd180;
   localparam logic [6:0]  DEG_90  = 7'd90;
   localparam logic [5:0]  DEG_45  = 6'd45;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_RIN, ST_CHECK, ST_SQ, ST_CMP, ST_TEST,
      ST_DIV, ST_ANG, ST_PREP, ST_EMIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ctr_col;
      logic signed [COORD_W-1:0] ctr_row;
      logic [RAD_W-1:0]          outer_radius;
      logic [RAD_W-1:0]          ring_thickness;
      logic [ANG_W-1:0]          angle_from;
      logic [ANG_W-1:0]          angle_to;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic init;
      logic rin;
      logic square;
      logic compare;
      logic div_start;
      logic update;
      logic next_x;
      logic prep;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic x_active;
      logic outside;
      logic inner;
      logic div_done;
      logic emit_last;
   } sts_type;

endpackage

>>> src/arsg_div.sv
module arsg_div
   import arsg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quot
);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quot_ff, quot_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // One quotient bit per cycle; the quotient never exceeds 45.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = {den, {(NUM_W-DEN_W){1'b0}}};
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[QUO_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'(QUO_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> src/arsg_datapath.sv
module arsg_datapath
   import arsg_pkg::*;
#(
   parameter int MAX_RADIUS = 1023
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  cfg_type                 cfg,
   input  logic signed [ROW_W-1:0] row_offset,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_span_left,
   output logic signed [OUT_W-1:0] rsp_span_row,
   output logic [LEN_W-1:0]        rsp_span_length,
   output logic [1:0]              rsp_span_quadrant,
   output logic                    rsp_last_span
);

   logic signed [ROW_W-1:0] yi_ff, xi_ff;
   logic [RAD_W-1:0]        r_ff, th_ff, rin_ff;
   logic [19:0]             ro2_ff, ri2_ff, xsq_ff;
   logic [20:0]             yi2_ff;
   logic                    outside_ff, inner_ff, steep_ff;
   logic [NUM_TESTS-1:0]    has_s_ff, has_e_ff, valid_ff;
   logic signed [ROW_W-1:0] xs_ff [NUM_TESTS];
   logic signed [11:0]      xe_ff [NUM_TESTS];
   logic signed [11:0]      end_ff [NUM_TESTS];
   logic [1:0]              k_ff;
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_left_ff, out_row_ff;
   logic [LEN_W-1:0]        out_len_ff;
   logic [1:0]              out_quad_ff;
   logic                    out_last_ff;

   logic [RAD_W-1:0]        r_sat, th_clamp;
   logic [RAD_W-1:0]        ax;
   logic [DEN_W-1:0]        ay;
   logic [21:0]             d2;
   logic                    steep;
   logic [RAD_W-1:0]        small_side;
   logic [NUM_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   logic                    div_done;
   logic [QUO_W-1:0]        quot;
   logic [2:0]              corr;
   logic [QUO_W-1:0]        dc;
   logic [6:0]              doct;
   logic [ANG_W-1:0]        deg;
   logic [15:0]             ang [NUM_TESTS];
   logic [NUM_TESTS-1:0]    pass;
   logic signed [11:0]      xi_m1;

   // Radius saturation and thickness clamp.
   always_comb begin
      r_sat    = (32'(cfg.outer_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                       : cfg.outer_radius;
      th_clamp = (cfg.ring_thickness > r_sat) ? r_sat : cfg.ring_thickness;
   end

   // Magnitudes of the point; x is never positive during the scan.
   always_comb begin
      ax = RAD_W'(-xi_ff);
      ay = yi_ff[ROW_W-1] ? DEN_W'(-yi_ff) : DEN_W'(yi_ff);
      d2 = 22'(xsq_ff) + 22'(yi2_ff);
      steep = DEN_W'(ax) > ay;
      small_side = steep ? RAD_W'(ay) : ax;
      div_num = NUM_W'(small_side) * NUM_W'(DEG_45);
      div_den = steep ? DEN_W'(ax) : ay;
      xi_m1 = {xi_ff[ROW_W-1], xi_ff} - 12'sd1;
   end

   arsg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // Correction ladder and mapping to the full circle.
   always_comb begin
      if (quot > 6'd22) begin
         corr = 3'(quot < 6'd45) + 3'(quot < 6'd42) + 3'(quot < 6'd38)
              + 3'(quot < 6'd33);
      end else begin
         corr = 3'(quot > 6'd1) + 3'(quot > 6'd5) + 3'(quot > 6'd9)
              + 3'(quot > 6'd14);
      end
      dc   = quot + QUO_W'(corr);
      doct = steep_ff ? (DEG_90 - 7'(dc)) : 7'(dc);
      if (yi_ff[ROW_W-1]) begin
         deg = ANG_W'(DEG_180) + ANG_W'(doct);
      end else begin
         deg = ANG_W'(DEG_360) - ANG_W'(doct);
      end
      ang[0] = 16'(deg);
      ang[1] = DEG_540 - 16'(deg);
      ang[2] = DEG_360 - 16'(deg);
      ang[3] = 16'(deg) - DEG_180;
      for (int k = 0; k < NUM_TESTS; k++) begin
         if (cfg.angle_from > cfg.angle_to) begin
            pass[k] = (ang[k] >= 16'(cfg.angle_from)) ||
                      (ang[k] <= 16'(cfg.angle_to));
         end else begin
            pass[k] = (ang[k] >= 16'(cfg.angle_from)) &&
                      (ang[k] <= 16'(cfg.angle_to));
         end
      end
   end

   // Scan registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         yi_ff <= row_offset;
         r_ff  <= r_sat;
         th_ff <= th_clamp;
      end
      if (cmd.init) begin
         rin_ff <= r_ff - th_ff;
         ro2_ff <= r_ff * r_ff;
         yi2_ff <= 21'(ay) * 21'(ay);
         xi_ff  <= -$signed({1'b0, r_ff});
      end
      if (cmd.rin) begin
         ri2_ff <= rin_ff * rin_ff;
      end
      if (cmd.square) begin
         xsq_ff <= ax * ax;
      end
      if (cmd.compare) begin
         outside_ff <= d2 > 22'(ro2_ff);
         inner_ff   <= d2 < 22'(ri2_ff);
         steep_ff   <= steep;
      end
      if (cmd.next_x) begin
         xi_ff <= xi_ff + 11'sd1;
      end
   end

   // Span tracking per mirrored test.
   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         has_s_ff <= '0;
         has_e_ff <= '0;
      end else if (cmd.update) begin
         for (int k = 0; k < NUM_TESTS; k++) begin
            if (pass[k]) begin
               if (!has_s_ff[k]) begin
                  has_s_ff[k] <= 1'b1;
                  xs_ff[k]    <= xi_ff;
               end
            end else if (has_s_ff[k] && !has_e_ff[k]) begin
               has_e_ff[k] <= 1'b1;
               xe_ff[k]    <= xi_m1;
            end
         end
      end
   end

   // Close the spans once the scan has stopped.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         for (int k = 0; k < NUM_TESTS; k++) begin
            end_ff[k]   <= has_e_ff[k] ? xe_ff[k] : xi_m1;
            valid_ff[k] <= has_s_ff[k] &&
                           ((has_e_ff[k] ? xe_ff[k] : xi_m1) >=
                            {xs_ff[k][ROW_W-1], xs_ff[k]});
         end
      end
   end

   // Result beat, one mirrored test per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         out_valid_ff <= cmd.emit && valid_ff[k_ff];
         if (cmd.prep) begin
            k_ff <= '0;
         end else if (cmd.emit) begin
            k_ff <= k_ff + 2'd1;
         end
      end
      if (cmd.emit) begin
         out_len_ff  <= LEN_W'(end_ff[k_ff] - {xs_ff[k_ff][ROW_W-1], xs_ff[k_ff]});
         out_quad_ff <= k_ff;
         out_last_ff <= (valid_ff >> k_ff) == NUM_TESTS'(1);
         if (!k_ff[1]) begin
            out_left_ff <= OUT_W'(cfg.ctr_col) - OUT_W'(end_ff[k_ff]);
         end else begin
            out_left_ff <= OUT_W'(cfg.ctr_col) + OUT_W'(xs_ff[k_ff]);
         end
         if (!k_ff[0]) begin
            out_row_ff <= OUT_W'(cfg.ctr_row) + OUT_W'(yi_ff);
         end else begin
            out_row_ff <= OUT_W'(cfg.ctr_row) - OUT_W'(yi_ff);
         end
      end
   end

   assign sts.x_active  = xi_ff[ROW_W-1];
   assign sts.outside   = outside_ff;
   assign sts.inner     = inner_ff;
   assign sts.div_done  = div_done;
   assign sts.emit_last = k_ff == 2'd3;

   assign rsp_valid         = out_valid_ff;
   assign rsp_span_left     = out_left_ff;
   assign rsp_span_row      = out_row_ff;
   assign rsp_span_length   = out_len_ff;
   assign rsp_span_quadrant = out_quad_ff;
   assign rsp_last_span     = out_last_ff;

endmodule

>>> src/arsg_ctrl.sv
module arsg_ctrl
   import arsg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_RIN;
         end
         ST_RIN: begin
            cmd.rin  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.x_active ? ST_SQ : ST_PREP;
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = ST_TEST;
         end
         ST_TEST: begin
            if (sts.outside) begin
               cmd.next_x = 1'b1;
               state_in   = ST_CHECK;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_ANG;
            end
         end
         ST_ANG: begin
            cmd.update = 1'b1;
            if (sts.inner) begin
               state_in = ST_PREP;
            end else begin
               cmd.next_x = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

>>> src/arc_row_span_generator.sv
// Ring-arc row span generator.
// A caller writes the six arc registers over the csr_ channel (index, data;
// csr_ready is always high) while the block is idle, then raises start with a
// row offset on req_row_offset. The row is taken when start is high and busy
// is low; busy stays high until the last span of the row has been shown.
// Spans come out on the rsp_ ports, each for exactly one cycle with
// rsp_valid high, in mirrored-test order, the final one with
// rsp_last_span set. A row may yield no span at all.
// Setup and drain states wrap the scan. Each scanned point outside the outer
// circle passes the check, square, compare and test states; a point inside it
// also waits on the angle divider, which dominates. At most outer_radius points
// are scanned; the next row can be taken as soon as busy falls.
// Reset returns the controller to idle and loads the register defaults.
// The receiver cannot stall; every beat is taken in the cycle it is shown.
module arc_row_span_generator
   import arsg_pkg::*;
#(
   parameter int MAX_RADIUS = 1023
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [ROW_W-1:0]     req_row_offset,
   output logic                        rsp_valid,
   output logic signed [OUT_W-1:0]     rsp_span_left,
   output logic signed [OUT_W-1:0]     rsp_span_row,
   output logic [LEN_W-1:0]            rsp_span_length,
   output logic [1:0]                  rsp_span_quadrant,
   output logic                        rsp_last_span,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_wdata
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ctr_col        <= '0;
         cfg_ff.ctr_row        <= '0;
         cfg_ff.outer_radius   <= RAD_W'(1);
         cfg_ff.ring_thickness <= '0;
         cfg_ff.angle_from     <= '0;
         cfg_ff.angle_to       <= ANG_W'(DEG_360);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X:  cfg_ff.ctr_col        <= csr_wdata;
            REG_CENTER_Y:  cfg_ff.ctr_row        <= csr_wdata;
            REG_RADIUS:    cfg_ff.outer_radius   <= csr_wdata[RAD_W-1:0];
            REG_THICKNESS: cfg_ff.ring_thickness <= csr_wdata[RAD_W-1:0];
            REG_START:     cfg_ff.angle_from     <= csr_wdata[ANG_W-1:0];
            REG_END:       cfg_ff.angle_to       <= csr_wdata[ANG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   arsg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   arsg_datapath #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg               (cfg_ff),
      .row_offset        (req_row_offset),
      .rsp_valid         (rsp_valid),
      .rsp_span_left     (rsp_span_left),
      .rsp_span_row      (rsp_span_row),
      .rsp_span_length   (rsp_span_length),
      .rsp_span_quadrant (rsp_span_quadrant),
      .rsp_last_span     (rsp_last_span)
   );

endmodule

>>> src/arsg_checker.sv
module arsg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_span
);

   // Spans appear only while a row is in progress.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("span beat while idle");

   // An accepted row makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("row accepted but block not busy");

   // The final span of a row is followed by no further beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_span) |=> !rsp_valid)
      else $error("beat after final span");

   // Reset leaves the block idle with no beat.
   assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind arc_row_span_generator arsg_checker u_arsg_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_last_span (rsp_last_span)
);

>>> tb/tb_arc_row_span_generator.sv
module tb_arc_row_span_generator;
   import arsg_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd6;

   typedef struct {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] row;
      logic [LEN_W-1:0]        length;
      logic [1:0]              quadrant;
      logic                    last;
   } span_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [ROW_W-1:0]  req_row_offset = '0;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_span_left;
   logic signed [OUT_W-1:0]  rsp_span_row;
   logic [LEN_W-1:0]         rsp_span_length;
   logic [1:0]               rsp_span_quadrant;
   logic                     rsp_last_span;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DAT_W-1:0]     csr_wdata = '0;

   // Shadow copy of the arc registers.
   cfg_type arc_cfg;

   logic signed [ROW_W-1:0] row_queue[$];
   span_beat_type           expected_spans[$];
   int                      error_count = 0;
   int                      cycle_count = 0;

   arc_row_span_generator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_row_offset(req_row_offset), .rsp_valid(rsp_valid),
      .rsp_span_left(rsp_span_left), .rsp_span_row(rsp_span_row),
      .rsp_span_length(rsp_span_length), .rsp_span_quadrant(rsp_span_quadrant),
      .rsp_last_span(rsp_last_span), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Coarse integer atan2 in degrees with the correction ladder.
   function automatic int arc_angle(input int x, input int y);
      int ux, uy, d, c;
      bit steep;
      ux = (x < 0) ? -x : x;
      uy = (y < 0) ? -y : y;
      steep = 0;
      if (uy < ux) begin
         d = (uy * 45) / ux;
         steep = 1;
      end else begin
         d = (uy != 0) ? (ux * 45) / uy : 0;
      end
      if (d > 22) begin
         c = int'(d < 45) + int'(d < 42) + int'(d < 38) + int'(d < 33);
      end else begin
         c = int'(d > 1) + int'(d > 5) + int'(d > 9) + int'(d > 14);
      end
      d += c;
      if (steep) d = 90 - d;
      if (y < 0) d = (x < 0) ? 180 + d : 180 - d;
      else if (x < 0) d = 360 - d;
      return d;
   endfunction

   // Negative angles wrap to large 16-bit values before the range test.
   function automatic bit angle_covered(input int a, input int s, input int e);
      int u;
      u = a & 16'hFFFF;
      if (s > e) return (u >= s) || (u <= e);
      return (u >= s) && (u <= e);
   endfunction

   // Scan the left half of one row and queue the spans it must produce.
   function automatic void predict_row_spans(input logic signed [ROW_W-1:0] row_in);
      int yi, cx, cy, r, th, rin, xi, k, d, end_x, s, e, first;
      longint ro2, ri2, d2;
      int ang[4];
      bit has_s[4], has_e[4];
      int xs[4], xe[4];
      span_beat_type beat;
      span_beat_type row_spans[$];
      yi = row_in;
      cx = arc_cfg.ctr_col;
      cy = arc_cfg.ctr_row;
      r = arc_cfg.outer_radius;
      if (r > 1023) r = 1023;
      th = arc_cfg.ring_thickness;
      if (th > r) th = r;
      rin = r - th;
      ro2 = longint'(r) * r;
      ri2 = longint'(rin) * rin;
      s = arc_cfg.angle_from;
      e = arc_cfg.angle_to;
      for (k = 0; k < 4; k++) begin
         has_s[k] = 0; has_e[k] = 0; xs[k] = 0; xe[k] = 0;
      end
      for (xi = -r; xi < 0; xi++) begin
         d2 = longint'(xi) * xi + longint'(yi) * yi;
         if (d2 > ro2) continue;
         d = arc_angle(xi, yi);
         ang[0] = d;
         ang[1] = 540 - d;
         ang[2] = 360 - d;
         ang[3] = d - 180;
         for (k = 0; k < 4; k++) begin
            if (angle_covered(ang[k], s, e)) begin
               if (!has_s[k]) begin
                  has_s[k] = 1;
                  xs[k] = xi;
               end
            end else if (has_s[k] && !has_e[k]) begin
               has_e[k] = 1;
               xe[k] = xi - 1;
            end
         end
         if (d2 < ri2) break;
      end
      for (k = 0; k < 4; k++) begin
         if (!has_s[k]) continue;
         end_x = has_e[k] ? xe[k] : xi - 1;
         if (end_x < xs[k]) continue;
         first = (k < 2) ? cx - end_x : cx + xs[k];
         beat.left = first[OUT_W-1:0];
         first = (k == 0 || k == 2) ? cy + yi : cy - yi;
         beat.row = first[OUT_W-1:0];
         first = end_x - xs[k];
         beat.length = first[LEN_W-1:0];
         beat.quadrant = k[1:0];
         beat.last = 1'b0;
         row_spans.push_back(beat);
      end
      if (row_spans.size() > 0) row_spans[row_spans.size()-1].last = 1'b1;
      foreach (row_spans[i]) expected_spans.push_back(row_spans[i]);
   endfunction

   // Row driver: bursts of requests separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_row_spans(req_row_offset);
         if (start && busy) begin
            // Hold the request until the block takes it.
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (row_queue.size() > 0) begin
            start <= 1'b1;
            req_row_offset <= row_queue.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Span monitor: every beat is taken in the cycle it is shown.
   always @(posedge clock) begin
      span_beat_type exp_beat;
      if (!reset && rsp_valid) begin
         if (expected_spans.size() == 0) begin
            report_mismatch($sformatf("unexpected span left %0d row %0d",
                                      rsp_span_left, rsp_span_row));
         end else begin
            exp_beat = expected_spans.pop_front();
            if (rsp_span_left !== exp_beat.left)
               report_mismatch($sformatf("span_left %0d, expected %0d",
                                         rsp_span_left, exp_beat.left));
            if (rsp_span_row !== exp_beat.row)
               report_mismatch($sformatf("span_row %0d, expected %0d",
                                         rsp_span_row, exp_beat.row));
            if (rsp_span_length !== exp_beat.length)
               report_mismatch($sformatf("span_length %0d, expected %0d",
                                         rsp_span_length, exp_beat.length));
            if (rsp_span_quadrant !== exp_beat.quadrant)
               report_mismatch($sformatf("span_quadrant %0d, expected %0d",
                                         rsp_span_quadrant, exp_beat.quadrant));
            if (rsp_last_span !== exp_beat.last)
               report_mismatch($sformatf("last_span %0b, expected %0b",
                                         rsp_last_span, exp_beat.last));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_arc_row_span_generator NOT OK");
         $finish;
      end
   end

   // Wait until every queued row has been processed and the block is idle.
   task automatic wait_idle();
      do @(posedge clock);
      while (row_queue.size() != 0 || start || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_spans.size() > 0) begin
         void'(expected_spans.pop_front());
         report_mismatch("expected span never arrived");
      end
   endtask

   // Write all six arc registers in one stream of beats.
   task automatic write_arc(input int cx, input int cy, input int r, input int th,
                            input int sa, input int ea);
      int vals[6];
      logic [CSR_IDX_W-1:0] idx[6];
      vals = '{cx, cy, r, th, sa, ea};
      idx = '{REG_CENTER_X, REG_CENTER_Y, REG_RADIUS, REG_THICKNESS, REG_START, REG_END};
      csr_valid <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i][CSR_DAT_W-1:0];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            REG_CENTER_X:  arc_cfg.ctr_col = vals[i][COORD_W-1:0];
            REG_CENTER_Y:  arc_cfg.ctr_row = vals[i][COORD_W-1:0];
            REG_RADIUS:    arc_cfg.outer_radius = vals[i][RAD_W-1:0];
            REG_THICKNESS: arc_cfg.ring_thickness = vals[i][RAD_W-1:0];
            REG_START:     arc_cfg.angle_from = vals[i][ANG_W-1:0];
            REG_END:       arc_cfg.angle_to = vals[i][ANG_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int r, n_rows, span;
      arc_cfg.ctr_col = '0;
      arc_cfg.ctr_row = '0;
      arc_cfg.outer_radius = 10'd1;
      arc_cfg.ring_thickness = '0;
      arc_cfg.angle_from = '0;
      arc_cfg.angle_to = 9'd360;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: unit radius, full circle; the row 2 lies beyond it.
      row_queue = '{0, 1, -1, 2};
      wait_idle();

      // A write to an unused index must change nothing.
      csr_valid <= 1'b1;
      csr_index <= REG_UNUSED;
      csr_wdata <= 12'hFFF;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      row_queue = '{0};
      wait_idle();

      // Zero radius scans nothing.
      write_arc(5, 5, 0, 0, 0, 360);
      row_queue = '{0, 1};
      wait_idle();

      // Largest radius, thickness equal to the radius, extreme centers.
      write_arc(-2048, 2047, 1023, 1023, 0, 360);
      row_queue = '{0, 1023, -1023};
      wait_idle();
      write_arc(2047, -2048, 1023, 0, 0, 360);
      row_queue = '{-1024, 700};
      wait_idle();

      // Thickness clamped to the radius with a wrapped angle range.
      write_arc(100, -100, 10, 1023, 300, 60);
      row_queue = '{-10, -7, -3, 0, 4, 9, 11};
      wait_idle();

      // Degenerate ranges: a single angle, and the 360 boundary.
      write_arc(0, 0, 12, 3, 360, 360);
      row_queue = '{0, -5, 6};
      wait_idle();
      write_arc(-7, 9, 16, 5, 90, 90);
      row_queue = '{-16, 0, 8};
      wait_idle();

      // Random phases, mostly small radii to keep rows short.
      for (int ph = 0; ph < 28; ph++) begin
         if (ph % 9 == 8) begin
            r = $urandom_range(200, 1023);
            n_rows = 2;
         end else begin
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 28);
            n_rows = $urandom_range(9, 18);
         end
         write_arc($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048, r,
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, r + 2),
                   $urandom_range(0, 360), $urandom_range(0, 360));
         span = r + 2;
         for (int i = 0; i < n_rows; i++) begin
            if ($urandom_range(0, 9) == 0)
               row_queue.push_back($urandom_range(0, 2046) - 1023);
            else
               row_queue.push_back($urandom_range(0, 2 * span) - span);
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb_arc_row_span_generator OK");
      end else begin
         $display("tb_arc_row_span_generator NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
src/arsg_pkg.sv
src/arsg_div.sv
src/arsg_datapath.sv
src/arsg_ctrl.sv
src/arc_row_span_generator.sv
src/arsg_checker.sv
tb/tb_arc_row_span_generator.sv
